### sv/sps_pkg.sv
// Shared types and constants for the sensor power sequencer.
// Used by every module of the block and by its checker; depends on nothing.
package sps_pkg;

   localparam int CHANNEL_COUNT = 8;
   localparam int TIMER_BITS    = 17;

   localparam int CHAN_BITS  = 3;
   localparam int KIND_BITS  = 2;
   localparam int DELAY_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Width for comparing the timer against a delay without losing bits on either side.
   localparam int CMP_BITS = (TIMER_BITS > DELAY_BITS) ? TIMER_BITS : DELAY_BITS;
   // Width for comparing a channel against the channel count.
   localparam int CNT_RAW_BITS = $clog2(CHANNEL_COUNT + 1);
   localparam int CNT_BITS = (CNT_RAW_BITS > CHAN_BITS) ? CNT_RAW_BITS : CHAN_BITS;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   localparam logic [DELAY_BITS-1:0] POWER_UP_RESET   = 16'd100;
   localparam logic [DELAY_BITS-1:0] POWER_DOWN_RESET = 16'd1000;
   localparam logic [DELAY_BITS-1:0] SETTLE_RESET     = 16'd10;

   localparam int REQ_TDATA_BITS = 8;
   localparam int RSP_TDATA_BITS = 16;

   typedef enum logic [2:0] {
      PH_IDLE         = 3'd0,
      PH_POWERING     = 3'd1,
      PH_POWERED_IDLE = 3'd2,
      PH_SETTLING     = 3'd3,
      PH_READY        = 3'd4
   } phase_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_TICK    = 2'd0,
      KIND_REQUEST = 2'd1,
      KIND_RELEASE = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POWER_UP   = 2'd0,
      CSR_POWER_DOWN = 2'd1,
      CSR_SETTLE     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DELAY_BITS-1:0] power_up_delay;
      logic [DELAY_BITS-1:0] power_down_delay;
      logic [DELAY_BITS-1:0] settle_delay;
   } cfg_type;

   typedef struct packed {
      logic                 ready_res;
      phase_type            phase;
      logic [CHAN_BITS-1:0] mux_select;
      logic                 sensor_power;
      logic                 accepted;
   } rsp_type;

endpackage

### sv/sps_regs.sv
// Delay registers of the sensor power sequencer, written through the csr port.
// Depends on sps_pkg.
module sps_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sps_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sps_pkg::DELAY_BITS-1:0]      csr_wdata,
   output sps_pkg::cfg_type                    cfg
);
   import sps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_POWER_UP:   cfg_in.power_up_delay   = csr_wdata;
            CSR_POWER_DOWN: cfg_in.power_down_delay = csr_wdata;
            CSR_SETTLE:     cfg_in.settle_delay     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_up_delay   <= POWER_UP_RESET;
         cfg_ff.power_down_delay <= POWER_DOWN_RESET;
         cfg_ff.settle_delay     <= SETTLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/sps_core.sv
// Phase state and next-state logic of the sensor power sequencer.
// Updates on each accepted request and forms its result; depends on sps_pkg.
module sps_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [sps_pkg::KIND_BITS-1:0]  kind,
   input  logic [sps_pkg::CHAN_BITS-1:0]  req_channel,
   input  sps_pkg::cfg_type               cfg,
   output sps_pkg::rsp_type               rsp
);
   import sps_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [CHAN_BITS-1:0]  held_ff, held_in;
   logic [CHAN_BITS-1:0]  mux_ff, mux_in;
   logic                  power_ff, power_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;

   logic [TIMER_BITS-1:0] elapsed_inc;
   logic [CMP_BITS-1:0]   elapsed_cmp;
   logic                  chan_ok;
   logic                  enter;
   phase_type             target;
   logic                  accepted;

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      mux_in     = mux_ff;
      power_in   = power_ff;
      elapsed_in = elapsed_ff;
      enter      = 1'b0;
      target     = phase_ff;
      accepted   = 1'b0;

      // saturating millisecond count
      elapsed_inc = (elapsed_ff == TIMER_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
      elapsed_cmp = CMP_BITS'(elapsed_inc);
      chan_ok     = CNT_BITS'(req_channel) < CNT_BITS'(CHANNEL_COUNT);

      case (kind_type'(kind))
         KIND_TICK: begin
            elapsed_in = elapsed_inc;
            case (phase_ff)
               PH_POWERING: begin
                  if (elapsed_cmp > CMP_BITS'(cfg.power_up_delay)) begin
                     mux_in = held_ff;
                     enter  = 1'b1;
                     target = PH_SETTLING;
                  end
               end
               PH_POWERED_IDLE: begin
                  if (elapsed_cmp > CMP_BITS'(cfg.power_down_delay)) begin
                     enter  = 1'b1;
                     target = PH_IDLE;
                  end
               end
               PH_SETTLING: begin
                  if (elapsed_cmp > CMP_BITS'(cfg.settle_delay)) begin
                     enter  = 1'b1;
                     target = PH_READY;
                  end
               end
               default: ;
            endcase
         end
         KIND_REQUEST: begin
            if (chan_ok) begin
               case (phase_ff)
                  PH_IDLE: begin
                     held_in  = req_channel;
                     enter    = 1'b1;
                     target   = PH_POWERING;
                     accepted = 1'b1;
                  end
                  PH_POWERED_IDLE: begin
                     // same channel is still on the mux: skip settling
                     if (req_channel != held_ff) begin
                        held_in = req_channel;
                        mux_in  = req_channel;
                        target  = PH_SETTLING;
                     end else begin
                        target  = PH_READY;
                     end
                     enter    = 1'b1;
                     accepted = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         KIND_RELEASE: begin
            enter  = 1'b1;
            target = (phase_ff > PH_POWERING) ? PH_POWERED_IDLE : PH_IDLE;
         end
         default: ;
      endcase

      if (enter) begin
         phase_in   = target;
         elapsed_in = '0;
         if (target == PH_IDLE) begin
            mux_in   = '0;
            power_in = 1'b0;
         end else if (target == PH_POWERING) begin
            power_in = 1'b1;
         end
      end

      rsp.accepted     = accepted;
      rsp.sensor_power = power_in;
      rsp.mux_select   = mux_in;
      rsp.phase        = phase_in;
      rsp.ready_res    = (phase_in == PH_READY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         held_ff    <= '0;
         mux_ff     <= '0;
         power_ff   <= 1'b0;
         elapsed_ff <= '0;
      end else if (load) begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         mux_ff     <= mux_in;
         power_ff   <= power_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

### sv/sps_out.sv
// Result register of the sensor power sequencer, holding one request's status
// until the downstream side takes it. Depends on sps_pkg.
module sps_out (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  sps_pkg::rsp_type                   rsp,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [sps_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);
   import sps_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = rsp;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'(data_ff);

endmodule

### sv/sensor_power_sequencer.sv
// Top level of the sensor power sequencer: delay registers, phase logic and
// result register. Depends on sps_pkg, sps_regs, sps_core and sps_out.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_tvalid / req_tready | tuser kind, tdata req_channel
//   rsp     | out       | rsp_tvalid / rsp_tready | tdata status of the phase
//   csr     | in        | csr_we                  | csr_index, csr_wdata
//
// One request per clock while the result is not stalled; its result shows in the cycle after acceptance.
// The single result register sets the rate: a request is taken whenever it is
// empty or being drained in the same cycle.
// Reset is synchronous: phase idle, power off, mux channel 0, delays 100/1000/10.
// A stalled result holds rsp_tdata and blocks further requests.
module sensor_power_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sps_pkg::REQ_TDATA_BITS-1:0]  req_tdata,   // [2:0] req_channel
   input  logic [sps_pkg::KIND_BITS-1:0]       req_tuser,   // [1:0] kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] accepted, [1] sensor_power, [4:2] mux_select, [7:5] phase, [8] ready_res
   output logic [sps_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_we,
   input  logic [sps_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sps_pkg::DELAY_BITS-1:0]      csr_wdata
);
   import sps_pkg::*;

   cfg_type cfg;
   rsp_type rsp;
   logic    load;

   assign req_tready = !rsp_tvalid || rsp_tready;
   assign load       = req_tvalid && req_tready;

   sps_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sps_core u_core (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .kind        (req_tuser),
      .req_channel (req_tdata[CHAN_BITS-1:0]),
      .cfg         (cfg),
      .rsp         (rsp)
   );

   sps_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .rsp        (rsp),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### sv/sps_checker.sv
// Port-level checks for the sensor power sequencer, bound to its top level.
// Depends on sps_pkg and sensor_power_sequencer.
module sps_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [sps_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata
);
   import sps_pkg::*;

   logic [2:0] phase;
   assign phase = rsp_tdata[7:5];

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8] == (phase == PH_READY))
      else $error("ready flag disagrees with phase");

   // idle always means power off and mux on channel zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && phase == PH_IDLE |-> !rsp_tdata[1] && rsp_tdata[4:2] == '0)
      else $error("idle with power or mux set");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0]
         |-> phase == PH_POWERING || phase == PH_SETTLING || phase == PH_READY)
      else $error("accepted request left block in wrong phase");

   // an accepted request always yields a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no result");

endmodule

bind sensor_power_sequencer sps_checker u_sps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/sensor_power_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sensor power sequencer: directed and random
// request streams, checked against a phase predictor kept in a small scoreboard.
// Depends on sps_pkg and sensor_power_sequencer.
module sensor_power_sequencer_test;
   import sps_pkg::*;

   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 2000;

   class status_scoreboard;
      phase_type             phase;
      logic [CHAN_BITS-1:0]  held_channel;
      logic [CHAN_BITS-1:0]  mux_value;
      logic                  power_on;
      logic [TIMER_BITS-1:0] elapsed_ms;
      logic [DELAY_BITS-1:0] power_up_delay;
      logic [DELAY_BITS-1:0] power_down_delay;
      logic [DELAY_BITS-1:0] settle_delay;
      rsp_type               expected_status[$];
      int                    error_count;

      function new();
         phase            = PH_IDLE;
         held_channel     = '0;
         mux_value        = '0;
         power_on         = 1'b0;
         elapsed_ms       = '0;
         power_up_delay   = POWER_UP_RESET;
         power_down_delay = POWER_DOWN_RESET;
         settle_delay     = SETTLE_RESET;
         error_count      = 0;
      endfunction

      function void set_delay(csr_index_type idx, logic [DELAY_BITS-1:0] value);
         case (idx)
            CSR_POWER_UP:   power_up_delay   = value;
            CSR_POWER_DOWN: power_down_delay = value;
            CSR_SETTLE:     settle_delay     = value;
            default: ;
         endcase
      endfunction

      function void enter_phase(phase_type next_phase);
         if (next_phase == PH_IDLE) begin
            mux_value = '0;
            power_on  = 1'b0;
         end else if (next_phase == PH_POWERING) begin
            power_on = 1'b1;
         end
         phase      = next_phase;
         elapsed_ms = '0;
      endfunction

      // Advance the phase for one accepted request and queue the status it yields.
      function void note_request(logic [KIND_BITS-1:0] kind, logic [CHAN_BITS-1:0] chan);
         rsp_type status;
         logic    taken;
         taken = 1'b0;
         case (kind)
            KIND_TICK: begin
               if (elapsed_ms != TIMER_MAX) elapsed_ms = elapsed_ms + 1'b1;
               case (phase)
                  PH_POWERING: begin
                     if (elapsed_ms > power_up_delay) begin
                        mux_value = held_channel;
                        enter_phase(PH_SETTLING);
                     end
                  end
                  PH_POWERED_IDLE: begin
                     if (elapsed_ms > power_down_delay) enter_phase(PH_IDLE);
                  end
                  PH_SETTLING: begin
                     if (elapsed_ms > settle_delay) enter_phase(PH_READY);
                  end
                  default: ;
               endcase
            end
            KIND_REQUEST: begin
               if (int'(chan) < CHANNEL_COUNT) begin
                  if (phase == PH_IDLE) begin
                     held_channel = chan;
                     enter_phase(PH_POWERING);
                     taken = 1'b1;
                  end else if (phase == PH_POWERED_IDLE) begin
                     if (chan != held_channel) begin
                        held_channel = chan;
                        mux_value    = chan;
                        enter_phase(PH_SETTLING);
                     end else begin
                        enter_phase(PH_READY);
                     end
                     taken = 1'b1;
                  end
               end
            end
            KIND_RELEASE: begin
               if (phase > PH_POWERING) enter_phase(PH_POWERED_IDLE);
               else enter_phase(PH_IDLE);
            end
            default: ;
         endcase
         status.accepted     = taken;
         status.sensor_power = power_on;
         status.mux_select   = mux_value;
         status.phase        = phase;
         status.ready_res    = (phase == PH_READY);
         expected_status.push_back(status);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
         end
      endfunction

      function void check_status(logic [RSP_TDATA_BITS-1:0] tdata);
         rsp_type got;
         rsp_type want;
         got = tdata[$bits(rsp_type)-1:0];
         if (expected_status.size() == 0) begin
            $error("status 0x%h with no request outstanding", tdata);
            error_count++;
            return;
         end
         want = expected_status.pop_front();
         compare_field("accepted", want.accepted, got.accepted);
         compare_field("sensor_power", want.sensor_power, got.sensor_power);
         compare_field("mux_select", want.mux_select, got.mux_select);
         compare_field("phase", want.phase, got.phase);
         compare_field("ready_res", want.ready_res, got.ready_res);
      endfunction

      function int outstanding();
         return expected_status.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_TDATA_BITS-1:0]   req_tdata  = '0;   // [2:0] req_channel
   logic [KIND_BITS-1:0]        req_tuser  = '0;   // [1:0] kind
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   // [0] accepted, [1] sensor_power, [4:2] mux_select, [7:5] phase, [8] ready_res
   logic [RSP_TDATA_BITS-1:0]   rsp_tdata;
   logic                        csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index  = '0;
   logic [DELAY_BITS-1:0]       csr_wdata  = '0;

   status_scoreboard board = new();

   bit hold_request = 1'b0;
   int burst_left   = 0;
   int quiet_cycles = 0;
   int stall_mode   = 0;
   int mode_left    = 0;
   int hold_left    = 0;

   sensor_power_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Check accepted status, then pick the next stall; a pending hold wins.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) board.check_status(rsp_tdata);
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = 64;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) == 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offer one request; gaps come between bursts of random length.
   task automatic send_item(logic [KIND_BITS-1:0] kind, logic [CHAN_BITS-1:0] chan);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_TDATA_BITS-CHAN_BITS){1'b0}}, chan};
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, chan);
   endtask

   // Drain every outstanding status, then load all three delays.
   task automatic configure(logic [DELAY_BITS-1:0] up, logic [DELAY_BITS-1:0] down,
                            logic [DELAY_BITS-1:0] settle);
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_POWER_UP;
      csr_wdata <= up;
      @(posedge clock);
      csr_index <= CSR_POWER_DOWN;
      csr_wdata <= down;
      @(posedge clock);
      csr_index <= CSR_SETTLE;
      csr_wdata <= settle;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_delay(CSR_POWER_UP, up);
      board.set_delay(CSR_POWER_DOWN, down);
      board.set_delay(CSR_SETTLE, settle);
   endtask

   task automatic random_phase(int count, bit with_hold);
      int                   pick;
      logic [KIND_BITS-1:0] kind;
      logic [CHAN_BITS-1:0] chan;
      for (int n = 0; n < count; n++) begin
         if (with_hold && n == count / 3) hold_request = 1'b1;
         pick = $urandom_range(0, 99);
         chan = CHAN_BITS'($urandom_range(0, CHANNEL_COUNT - 1));
         if (pick < 68) begin
            kind = KIND_TICK;
         end else if (pick < 85) begin
            kind = KIND_REQUEST;
            // favor the held channel so powered idle often jumps straight to ready
            if ($urandom_range(0, 2) == 0) chan = board.held_channel;
         end else if (pick < 97) begin
            kind = KIND_RELEASE;
         end else begin
            kind = KIND_UNUSED;
         end
         send_item(kind, chan);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset delays: power-up must not expire on a single tick
      send_item(KIND_REQUEST, 3'd5);
      send_item(KIND_TICK, 3'd2);
      send_item(KIND_RELEASE, 3'd0);

      configure(16'd1, 16'd2, 16'd0);
      send_item(KIND_UNUSED, 3'd7);
      send_item(KIND_RELEASE, 3'd0);
      send_item(KIND_REQUEST, 3'd7);
      send_item(KIND_REQUEST, 3'd3);   // refused while powering up
      send_item(KIND_TICK, 3'd0);
      send_item(KIND_TICK, 3'd0);
      send_item(KIND_REQUEST, 3'd1);   // refused while settling
      send_item(KIND_TICK, 3'd0);
      send_item(KIND_REQUEST, 3'd2);   // refused when ready
      send_item(KIND_TICK, 3'd0);
      send_item(KIND_RELEASE, 3'd0);
      send_item(KIND_REQUEST, 3'd7);   // same channel while powered
      send_item(KIND_RELEASE, 3'd0);
      send_item(KIND_TICK, 3'd0);
      send_item(KIND_RELEASE, 3'd0);   // re-enter powered idle, timer cleared
      send_item(KIND_TICK, 3'd0);
      send_item(KIND_TICK, 3'd0);
      send_item(KIND_REQUEST, 3'd0);   // different channel while powered
      send_item(KIND_RELEASE, 3'd0);
      send_item(KIND_TICK, 3'd0);
      send_item(KIND_TICK, 3'd0);
      send_item(KIND_TICK, 3'd0);
      send_item(KIND_REQUEST, 3'd2);
      send_item(KIND_RELEASE, 3'd0);   // release during power-up drops to idle
      send_item(KIND_UNUSED, 3'd5);

      configure(16'd0, 16'd0, 16'd0);
      random_phase(200, 1'b1);
      configure(16'd3, 16'd5, 16'd2);
      random_phase(200, 1'b0);
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(120, 1'b0);
      configure(16'd0, 16'hFFFF, 16'd0);
      random_phase(150, 1'b1);
      configure(16'hFFFF, 16'd0, 16'hFFFF);
      random_phase(100, 1'b0);
      repeat (4) begin
         configure(DELAY_BITS'($urandom_range(0, 8)), DELAY_BITS'($urandom_range(0, 8)),
                   DELAY_BITS'($urandom_range(0, 8)));
         random_phase(180, 1'b0);
      end

      // a long power-up delay must still expire exactly on its boundary
      configure(16'd60, 16'd3, 16'd2);
      send_item(KIND_RELEASE, 3'd0);
      send_item(KIND_REQUEST, 3'd6);
      repeat (64) send_item(KIND_TICK, CHAN_BITS'($urandom_range(0, CHANNEL_COUNT - 1)));

      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (board.error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
